// File: design/boad_pkg.sv
// shared types, constants and helpers for the ber object identifier arc decoder
// no dependencies; used by boad_front, boad_queue, boad_back and the top level
package boad_pkg;

    localparam int ARC_WIDTH_DEF = 32;
    localparam int OUT_WIDTH     = 32;
    localparam int BYTE_WIDTH    = 8;
    localparam int DIGIT_WIDTH   = 7;
    localparam int QDEPTH        = 4;
    localparam int QPTR_WIDTH    = $clog2(QDEPTH);
    localparam int QCNT_WIDTH    = $clog2(QDEPTH + 1);

    localparam logic [7:0]  FIRST_DIVISOR = 8'd40;
    // floor(b / 40) == (b * 205) >> 13 for every 8-bit b
    localparam logic [15:0] DIV40_RECIP   = 16'd205;
    localparam int          DIV40_SHIFT   = 13;

    typedef struct packed {
        logic                 first;
        logic [OUT_WIDTH-1:0] value;
        logic                 ovf;
        logic                 last;
    } entry_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
    } qstat_t;

    function automatic logic [2:0] div40(input logic [7:0] b);
        logic [15:0] prod;
        prod = {8'd0, b} * DIV40_RECIP;
        return prod[DIV40_SHIFT +: 3];
    endfunction

    function automatic logic [5:0] mod40(input logic [7:0] b);
        logic [7:0] q8;
        logic [7:0] sub;
        q8  = {5'd0, div40(b)};
        sub = 8'(q8 * FIRST_DIVISOR);
        return 6'(b - sub);
    endfunction

endpackage

// File: design/ber_oid_arc_decoder.sv
// top level of the ber object identifier arc decoder
// depends on boad_pkg, boad_front, boad_queue, boad_back
//
//  channel  dir  tdata               tuser         tlast
//  s_axis   in   content_byte[7:0]   -             last_byte
//  m_axis   out  arc_value[31:0]     arc_overflow  last_arc
//
// one byte accepted per cycle while the request queue is not full; a first byte
// makes two results in the back end, other bytes at most one
// from byte to result the path holds a queue entry and the output register
// reset clears the arc state, queue pointers and output valid; no clearing pass
// the front stalls only when the four-entry request queue is full
module ber_oid_arc_decoder #(
    parameter int ARC_WIDTH = boad_pkg::ARC_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // content_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // arc_value[31:0]
    output logic        m_axis_tuser,   // arc_overflow
    output logic        m_axis_tlast
);

    logic             q_push;
    logic             q_pop;
    logic             back_phase;
    boad_pkg::entry_t push_entry;
    boad_pkg::entry_t q_head;
    boad_pkg::qstat_t q_stat;

    boad_front #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .q_full     (q_stat.full),
        .push       (q_push),
        .push_entry (push_entry)
    );

    boad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    boad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_stat.empty),
        .pop       (q_pop),
        .phase     (back_phase),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_ovf   (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // no request pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("push into full queue");

    // no request taken from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // while the remainder of a first byte is pending, the quotient is on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        back_phase |-> (m_axis_tvalid && !m_axis_tlast && !m_axis_tuser && !q_stat.empty))
        else $error("first byte split lost");

    // a quotient result leaves the back end holding the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(back_phase) |-> $past(!q_pop))
        else $error("first byte popped early");

endmodule

// File: design/boad_front.sv
// front end: accepts content bytes, collects base-128 arcs, queues requests
// depends on boad_pkg
module boad_front #(
    parameter int ARC_WIDTH = boad_pkg::ARC_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             q_full,
    output logic             push,
    output boad_pkg::entry_t push_entry
);

    logic                 first_reg;
    logic                 first_next;
    logic [ARC_WIDTH-1:0] acc_reg;
    logic [ARC_WIDTH-1:0] acc_next;
    logic                 ovf_reg;
    logic                 ovf_next;

    logic                 accept;
    logic                 arc_end;
    logic                 ovf_hit;
    logic [ARC_WIDTH-1:0] acc_shift;
    logic [63:0]          acc_wide;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign arc_end   = !in_byte[7] || in_last;
    assign ovf_hit   = |acc_reg[ARC_WIDTH-1 -: boad_pkg::DIGIT_WIDTH];
    assign acc_shift = {acc_reg[ARC_WIDTH-1-boad_pkg::DIGIT_WIDTH:0],
                        in_byte[boad_pkg::DIGIT_WIDTH-1:0]};
    assign acc_wide  = 64'(acc_shift);
    assign push      = accept && (first_reg || arc_end);

    always_comb
    begin
        push_entry.first = first_reg;
        push_entry.last  = in_last;
        if (first_reg)
        begin
            push_entry.value = 32'(in_byte);
            push_entry.ovf   = 1'b0;
        end
        else
        begin
            push_entry.value = acc_wide[boad_pkg::OUT_WIDTH-1:0];
            push_entry.ovf   = ovf_reg || ovf_hit;
        end
    end

    always_comb
    begin
        first_next = first_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (first_reg)
            begin
                first_next = in_last;
                acc_next   = '0;
                ovf_next   = 1'b0;
            end
            else if (arc_end)
            begin
                first_next = in_last;
                acc_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                acc_next = acc_shift;
                ovf_next = ovf_reg || ovf_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: design/boad_queue.sv
// short fifo of arc requests between front and back end
// depends on boad_pkg
module boad_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  boad_pkg::entry_t push_entry,
    input  logic             pop,
    output boad_pkg::entry_t head,
    output boad_pkg::qstat_t stat
);

    boad_pkg::entry_t                mem [boad_pkg::QDEPTH];
    logic [boad_pkg::QPTR_WIDTH-1:0] wr_reg;
    logic [boad_pkg::QPTR_WIDTH-1:0] wr_next;
    logic [boad_pkg::QPTR_WIDTH-1:0] rd_reg;
    logic [boad_pkg::QPTR_WIDTH-1:0] rd_next;
    logic [boad_pkg::QCNT_WIDTH-1:0] cnt_reg;
    logic [boad_pkg::QCNT_WIDTH-1:0] cnt_next;

    localparam logic [boad_pkg::QPTR_WIDTH-1:0] PTR_LAST = boad_pkg::QPTR_WIDTH'(boad_pkg::QDEPTH - 1);
    localparam logic [boad_pkg::QCNT_WIDTH-1:0] CNT_FULL = boad_pkg::QCNT_WIDTH'(boad_pkg::QDEPTH);

    assign head       = mem[rd_reg];
    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: design/boad_back.sv
// back end: turns queued requests into arc results, splits the first byte in two
// depends on boad_pkg
module boad_back (
    input  logic             clk,
    input  logic             rst_n,
    input  boad_pkg::entry_t head,
    input  logic             q_empty,
    output logic             pop,
    output logic             phase,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      out_value,
    output logic             out_ovf,
    output logic             out_last
);

    logic        phase_reg;
    logic        phase_next;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        last_reg;
    logic        last_next;
    logic        load;

    assign load      = !valid_reg || out_ready;
    assign phase     = phase_reg;
    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_ovf   = ovf_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        valid_next = valid_reg;
        value_next = value_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (head.first && !phase_reg)
                begin
                    // quotient arc first, entry stays for the remainder
                    value_next = 32'(boad_pkg::div40(head.value[7:0]));
                    ovf_next   = 1'b0;
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    value_next = head.first ? 32'(boad_pkg::mod40(head.value[7:0]))
                                            : head.value;
                    ovf_next   = head.ovf;
                    last_next  = head.last;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
    end

endmodule
